// ----- design/sccp_pkg.sv -----
// ----------------------------------------------------------------------------
// sccp_pkg
// Operation, status and transfer codes of the sector cache policy block.
// ----------------------------------------------------------------------------
package sccp_pkg;

    localparam logic [2:0] OP_ACQUIRE = 3'd0;
    localparam logic [2:0] OP_RELEASE = 3'd1;
    localparam logic [2:0] OP_GET     = 3'd2;
    localparam logic [2:0] OP_DIRTY   = 3'd3;
    localparam logic [2:0] OP_DEALLOC = 3'd4;
    localparam logic [2:0] OP_FLUSH   = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BUSY   = 2'd1;
    localparam logic [1:0] ST_NOTF   = 2'd2;
    localparam logic [1:0] ST_NODATA = 2'd3;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_WB    = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_ZERO  = 2'd3;

    localparam logic [7:0] RCNT_MAX  = 8'd255;

endpackage

// ----- design/sector_cache_clock_policy.sv -----
// ----------------------------------------------------------------------------
// sector_cache_clock_policy
// Fully associative sector cache tag store with clock second-chance victim
// selection and per-slot reader/writer locks.
// ----------------------------------------------------------------------------
// One item at a time. Release, get data, mark dirty, flush and undefined
// operations take a tag read, then the update. Acquire and deallocate scan
// the tag memory one slot per cycle through its single read port; a miss is
// decided after the last slot is compared, and a hit ends the scan early. An
// acquire that misses with no empty slot then steps the clock hand one slot
// per cycle, up to 2*SLOTS steps, then issues the write-back (if the victim
// is filled and dirty) and the grant. in_ready is high only between items;
// each result waits in the output register until taken.
module sector_cache_clock_policy #(
    parameter int SLOTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [31:0] sector,
    input  logic        exclusive,
    input  logic        zero_fill,
    input  logic [5:0]  slot,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [5:0]  slot_index,
    output logic        hit,
    output logic [1:0]  action,
    output logic [31:0] disk_sector,
    output logic        last
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WAIT  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_GRANT = 3'd4;
    localparam logic [2:0] S_SWEEP = 3'd5;
    localparam logic [2:0] S_VICT  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]       state_reg;
    logic [2:0]       op_reg;
    logic [31:0]      sec_reg;
    logic             excl_reg;
    logic             zf_reg;
    logic [5:0]       slot_reg;
    logic [SW-1:0]    ptr_reg;
    logic [SW:0]      cnt_reg;
    logic             cmp_vld_reg;
    logic [SW-1:0]    cmp_ptr_reg;
    logic             empty_found_reg;
    logic [SW-1:0]    empty_idx_reg;
    logic             hit_reg;
    logic             fail_reg;
    logic [SW+1:0]    nsw_reg;
    logic [SW-1:0]    hand_reg;
    logic [31:0]      tag_q_reg;
    logic [7:0]       rc_q_reg;

    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] acc_reg;
    logic [SLOTS-1:0] dirty_reg;
    logic [SLOTS-1:0] filled_reg;
    logic [SLOTS-1:0] writer_reg;
    logic [SLOTS-1:0] readers_reg;

    logic             out_valid_reg;
    logic [1:0]       status_reg;
    logic [5:0]       slot_index_reg;
    logic             hit_out_reg;
    logic [1:0]       action_reg;
    logic [31:0]      disk_reg;
    logic             last_reg;

    logic [31:0]      tag_mem [SLOTS];
    logic [7:0]       rcnt_mem [SLOTS];

    logic             out_free;
    logic             out_load;
    logic [SW-1:0]    scan_addr;
    logic             issue;
    logic [SW-1:0]    rd_addr;
    logic [SW-1:0]    ptr_inc;
    logic [7:0]       rc;
    logic             wh;
    logic             locked;
    logic             can_take;
    logic             in_range;
    logic             tag_hit;
    logic             tag_we;
    logic             rc_we;
    logic [7:0]       rc_wdata;
    logic [1:0]       exec_status;
    logic [1:0]       exec_action;
    logic [31:0]      exec_disk;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = out_free && ((state_reg == S_EXEC) || (state_reg == S_GRANT) ||
                                    (state_reg == S_DONE) ||
                                    ((state_reg == S_VICT) && filled_reg[ptr_reg] &&
                                     dirty_reg[ptr_reg]));
    assign scan_addr = cnt_reg[SW-1:0];
    assign issue     = (cnt_reg < (SW+1)'(SLOTS));
    // on the scan's last cycle, point the read port at the slot to be granted
    assign rd_addr   = (state_reg != S_SCAN) ? ptr_reg :
                       tag_hit               ? cmp_ptr_reg :
                       issue                 ? scan_addr : empty_idx_reg;
    assign ptr_inc   = (ptr_reg == SW'(SLOTS - 1)) ? '0 : ptr_reg + 1'b1;
    assign rc        = readers_reg[ptr_reg] ? rc_q_reg : 8'd0;
    assign wh        = writer_reg[ptr_reg];
    assign locked    = readers_reg[ptr_reg] || wh;
    assign can_take  = excl_reg ? !locked : !(wh || rc == sccp_pkg::RCNT_MAX);
    assign in_range  = (32'(slot_reg) < 32'(SLOTS));
    assign tag_hit   = cmp_vld_reg && valid_reg[cmp_ptr_reg] && (tag_q_reg == sec_reg);
    assign tag_we    = (state_reg == S_GRANT) && out_free && !hit_reg;
    assign rc_we     = out_free && !excl_reg &&
                       (((state_reg == S_EXEC) && (op_reg == sccp_pkg::OP_RELEASE) &&
                         in_range && (rc != 8'd0)) ||
                        ((state_reg == S_GRANT) && can_take));
    assign rc_wdata  = (state_reg == S_EXEC) ? rc - 8'd1 : rc + 8'd1;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign slot_index  = slot_index_reg;
    assign hit         = hit_out_reg;
    assign action      = action_reg;
    assign disk_sector = disk_reg;
    assign last        = last_reg;

    // result of the single-slot operations
    always_comb
    begin
        exec_status = sccp_pkg::ST_OK;
        exec_action = sccp_pkg::ACT_NONE;
        exec_disk   = '0;
        if (op_reg <= sccp_pkg::OP_FLUSH && !in_range)
        begin
            exec_status = sccp_pkg::ST_NOTF;
        end
        else if (op_reg <= sccp_pkg::OP_FLUSH && op_reg != sccp_pkg::OP_RELEASE)
        begin
            if (!valid_reg[ptr_reg])
            begin
                exec_status = sccp_pkg::ST_NOTF;
            end
            else if (op_reg == sccp_pkg::OP_GET)
            begin
                if (zf_reg)
                begin
                    exec_action = sccp_pkg::ACT_ZERO;
                end
                else if (!filled_reg[ptr_reg])
                begin
                    exec_action = sccp_pkg::ACT_READ;
                    exec_disk   = tag_q_reg;
                end
            end
            else if (op_reg == sccp_pkg::OP_DIRTY)
            begin
                if (!filled_reg[ptr_reg])
                begin
                    exec_status = sccp_pkg::ST_NODATA;
                end
            end
            else if (locked)
            begin
                exec_status = sccp_pkg::ST_BUSY;
            end
            else if (filled_reg[ptr_reg] && dirty_reg[ptr_reg])
            begin
                exec_action = sccp_pkg::ACT_WB;
                exec_disk   = tag_q_reg;
            end
        end
    end

    // tag and reader count memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[ptr_reg] <= sec_reg;
        end
        if (rc_we)
        begin
            rcnt_mem[ptr_reg] <= rc_wdata;
        end
        tag_q_reg <= tag_mem[rd_addr];
        rc_q_reg  <= rcnt_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= '0;
            sec_reg         <= '0;
            excl_reg        <= 1'b0;
            zf_reg          <= 1'b0;
            slot_reg        <= '0;
            ptr_reg         <= '0;
            cnt_reg         <= '0;
            cmp_vld_reg     <= 1'b0;
            cmp_ptr_reg     <= '0;
            empty_found_reg <= 1'b0;
            empty_idx_reg   <= '0;
            hit_reg         <= 1'b0;
            fail_reg        <= 1'b0;
            nsw_reg         <= '0;
            hand_reg        <= SW'(SLOTS - 1);
            valid_reg       <= '0;
            acc_reg         <= '0;
            dirty_reg       <= '0;
            filled_reg      <= '0;
            writer_reg      <= '0;
            readers_reg     <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= '0;
            slot_index_reg  <= '0;
            hit_out_reg     <= 1'b0;
            action_reg      <= '0;
            disk_reg        <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            if (out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg          <= operation;
                        sec_reg         <= sector;
                        excl_reg        <= exclusive;
                        zf_reg          <= zero_fill;
                        slot_reg        <= slot;
                        ptr_reg         <= SW'(slot);
                        cnt_reg         <= '0;
                        cmp_vld_reg     <= 1'b0;
                        empty_found_reg <= 1'b0;
                        hit_reg         <= 1'b0;
                        fail_reg        <= 1'b0;
                        if (operation == sccp_pkg::OP_ACQUIRE ||
                            operation == sccp_pkg::OP_DEALLOC)
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_WAIT;
                        end
                    end
                end
                S_WAIT:
                begin
                    // tag and reader count of the addressed slot land in the read registers
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        status_reg     <= exec_status;
                        slot_index_reg <= (op_reg > sccp_pkg::OP_FLUSH) ? '0 : slot_reg;
                        hit_out_reg    <= 1'b0;
                        action_reg     <= exec_action;
                        disk_reg       <= exec_disk;
                        last_reg       <= 1'b1;
                        state_reg      <= S_IDLE;
                        if (op_reg <= sccp_pkg::OP_FLUSH && in_range)
                        begin
                            if (op_reg == sccp_pkg::OP_RELEASE)
                            begin
                                if (excl_reg)
                                begin
                                    writer_reg[ptr_reg] <= 1'b0;
                                end
                                else if (rc != 8'd0)
                                begin
                                    readers_reg[ptr_reg] <= (rc != 8'd1);
                                end
                            end
                            else if (valid_reg[ptr_reg])
                            begin
                                if (op_reg == sccp_pkg::OP_GET)
                                begin
                                    acc_reg[ptr_reg] <= 1'b1;
                                    if (zf_reg)
                                    begin
                                        dirty_reg[ptr_reg]  <= 1'b1;
                                        filled_reg[ptr_reg] <= 1'b1;
                                    end
                                    else if (!filled_reg[ptr_reg])
                                    begin
                                        dirty_reg[ptr_reg]  <= 1'b0;
                                        filled_reg[ptr_reg] <= 1'b1;
                                    end
                                end
                                else if (op_reg == sccp_pkg::OP_DIRTY)
                                begin
                                    if (filled_reg[ptr_reg])
                                    begin
                                        dirty_reg[ptr_reg] <= 1'b1;
                                    end
                                end
                                else if (!locked && filled_reg[ptr_reg] &&
                                         dirty_reg[ptr_reg])
                                begin
                                    dirty_reg[ptr_reg] <= 1'b0;
                                end
                            end
                        end
                    end
                end
                S_SCAN:
                begin
                    cmp_vld_reg <= issue;
                    if (issue)
                    begin
                        cnt_reg     <= cnt_reg + 1'b1;
                        cmp_ptr_reg <= scan_addr;
                        if (!valid_reg[scan_addr] && !empty_found_reg)
                        begin
                            empty_found_reg <= 1'b1;
                            empty_idx_reg   <= scan_addr;
                        end
                    end
                    if (tag_hit)
                    begin
                        ptr_reg   <= cmp_ptr_reg;
                        hit_reg   <= 1'b1;
                        state_reg <= (op_reg == sccp_pkg::OP_ACQUIRE) ? S_GRANT : S_DONE;
                    end
                    else if (!issue && !cmp_vld_reg)
                    begin
                        if (op_reg != sccp_pkg::OP_ACQUIRE)
                        begin
                            state_reg <= S_DONE;
                        end
                        else if (empty_found_reg)
                        begin
                            ptr_reg   <= empty_idx_reg;
                            state_reg <= S_GRANT;
                        end
                        else
                        begin
                            ptr_reg   <= (hand_reg == SW'(SLOTS - 1)) ? '0
                                                                      : hand_reg + 1'b1;
                            nsw_reg   <= '0;
                            state_reg <= S_SWEEP;
                        end
                    end
                end
                S_SWEEP:
                begin
                    hand_reg <= ptr_reg;
                    if (locked || acc_reg[ptr_reg])
                    begin
                        // second chance: clear the access bit of an unlocked slot and move on
                        acc_reg[ptr_reg] <= acc_reg[ptr_reg] & locked;
                        ptr_reg          <= ptr_inc;
                        nsw_reg          <= nsw_reg + 1'b1;
                        if (nsw_reg == (SW+2)'(2 * SLOTS - 1))
                        begin
                            fail_reg  <= 1'b1;
                            state_reg <= S_DONE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_VICT;
                    end
                end
                S_VICT:
                begin
                    if (!(filled_reg[ptr_reg] && dirty_reg[ptr_reg]))
                    begin
                        state_reg <= S_GRANT;
                    end
                    else if (out_free)
                    begin
                        out_valid_reg      <= 1'b1;
                        status_reg         <= sccp_pkg::ST_OK;
                        slot_index_reg     <= 6'(ptr_reg);
                        hit_out_reg        <= 1'b0;
                        action_reg         <= sccp_pkg::ACT_WB;
                        disk_reg           <= tag_q_reg;
                        last_reg           <= 1'b0;
                        dirty_reg[ptr_reg] <= 1'b0;
                        state_reg          <= S_GRANT;
                    end
                end
                S_GRANT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        status_reg     <= (hit_reg && !can_take) ? sccp_pkg::ST_BUSY
                                                                 : sccp_pkg::ST_OK;
                        slot_index_reg <= 6'(ptr_reg);
                        hit_out_reg    <= hit_reg;
                        action_reg     <= sccp_pkg::ACT_NONE;
                        disk_reg       <= '0;
                        last_reg       <= 1'b1;
                        state_reg      <= S_IDLE;
                        if (can_take)
                        begin
                            if (excl_reg)
                            begin
                                writer_reg[ptr_reg] <= 1'b1;
                            end
                            else
                            begin
                                readers_reg[ptr_reg] <= 1'b1;
                            end
                        end
                        if (!hit_reg)
                        begin
                            valid_reg[ptr_reg]  <= 1'b1;
                            acc_reg[ptr_reg]    <= 1'b0;
                            dirty_reg[ptr_reg]  <= 1'b0;
                            filled_reg[ptr_reg] <= 1'b0;
                        end
                    end
                end
                S_DONE:
                begin
                    // deallocate result, or busy after a fruitless sweep
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        status_reg     <= fail_reg ? sccp_pkg::ST_BUSY :
                                          !hit_reg ? sccp_pkg::ST_NOTF :
                                          locked   ? sccp_pkg::ST_BUSY : sccp_pkg::ST_OK;
                        slot_index_reg <= (fail_reg || !hit_reg) ? '0 : 6'(ptr_reg);
                        hit_out_reg    <= 1'b0;
                        action_reg     <= sccp_pkg::ACT_NONE;
                        disk_reg       <= '0;
                        last_reg       <= 1'b1;
                        state_reg      <= S_IDLE;
                        if (!fail_reg && hit_reg && !locked)
                        begin
                            valid_reg[ptr_reg] <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while one is in progress");

    a_first_is_wb: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (action == sccp_pkg::ACT_WB))
        else $error("non-final result is not a write-back");

    a_hit_no_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hit) |-> (action == sccp_pkg::ACT_NONE))
        else $error("hit result requests a disk transfer");

    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> (nsw_reg < (SW+2)'(2 * SLOTS)))
        else $error("clock sweep ran past two turns");

endmodule

// ----- verif/tb_sector_cache_clock_policy.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sector_cache_clock_policy
// Drives directed and random cache operations through the valid/ready ports,
// predicts every result with a behavioral model of the tag and clock policy,
// and compares each result with its prediction in order.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot_index;
    logic        hit;
    logic [1:0]  action;
    logic [31:0] disk_sector;
    logic        last;
} cache_result_t;

class cache_scoreboard;
    localparam int NSLOT = 64;
    logic [31:0]   tags[NSLOT];
    bit            vld[NSLOT], acc[NSLOT], drt[NSLOT], fil[NSLOT], wr[NSLOT];
    logic [7:0]    rd[NSLOT];
    int            hand;
    cache_result_t pending[$];
    int            errors;

    function new();
        for (int i = 0; i < NSLOT; i++)
        begin
            tags[i] = '0; vld[i] = 0; acc[i] = 0; drt[i] = 0;
            fil[i] = 0; wr[i] = 0; rd[i] = '0;
        end
        hand = NSLOT - 1;
        errors = 0;
    endfunction

    function void push(logic [1:0] st, int s, bit h, logic [1:0] act,
                       logic [31:0] dsk, bit lst);
        cache_result_t r;
        r.status = st; r.slot_index = s[5:0]; r.hit = h; r.action = act;
        r.disk_sector = dsk; r.last = lst;
        pending.push_back(r);
    endfunction

    function bit locked(int i);
        return rd[i] != 0 || wr[i];
    endfunction

    function bit grab(int i, bit ex);
        if (ex)
        begin
            if (locked(i)) return 0;
            wr[i] = 1;
        end
        else
        begin
            if (wr[i] || rd[i] == sccp_pkg::RCNT_MAX) return 0;
            rd[i]++;
        end
        return 1;
    endfunction

    function void claim(int i, logic [31:0] sec, bit ex);
        bit ok;
        tags[i] = sec; vld[i] = 1; acc[i] = 0; drt[i] = 0; fil[i] = 0;
        ok = grab(i, ex);
    endfunction

    function void acquire(logic [31:0] sec, bit ex);
        for (int i = 0; i < NSLOT; i++)
            if (vld[i] && tags[i] == sec)
            begin
                push(grab(i, ex) ? sccp_pkg::ST_OK : sccp_pkg::ST_BUSY, i, 1,
                     sccp_pkg::ACT_NONE, 0, 1);
                return;
            end
        for (int i = 0; i < NSLOT; i++)
            if (!vld[i])
            begin
                claim(i, sec, ex);
                push(sccp_pkg::ST_OK, i, 0, sccp_pkg::ACT_NONE, 0, 1);
                return;
            end
        for (int n = 0; n < 2 * NSLOT; n++)
        begin
            hand = (hand + 1 >= NSLOT) ? 0 : hand + 1;
            if (locked(hand)) continue;
            if (acc[hand])
            begin
                acc[hand] = 0;
                continue;
            end
            if (fil[hand] && drt[hand])
                push(sccp_pkg::ST_OK, hand, 0, sccp_pkg::ACT_WB, tags[hand], 0);
            claim(hand, sec, ex);
            push(sccp_pkg::ST_OK, hand, 0, sccp_pkg::ACT_NONE, 0, 1);
            return;
        end
        push(sccp_pkg::ST_BUSY, 0, 0, sccp_pkg::ACT_NONE, 0, 1);
    endfunction

    // note an accepted input item and queue what it must produce
    function void note_item(logic [2:0] op, logic [31:0] sec, bit ex, bit zf,
                            logic [5:0] sl);
        int s;
        s = sl;
        case (op)
            sccp_pkg::OP_ACQUIRE: acquire(sec, ex);
            sccp_pkg::OP_DEALLOC:
            begin
                for (int i = 0; i < NSLOT; i++)
                    if (vld[i] && tags[i] == sec)
                    begin
                        if (locked(i)) push(sccp_pkg::ST_BUSY, i, 0, sccp_pkg::ACT_NONE, 0, 1);
                        else
                        begin
                            vld[i] = 0;
                            push(sccp_pkg::ST_OK, i, 0, sccp_pkg::ACT_NONE, 0, 1);
                        end
                        return;
                    end
                push(sccp_pkg::ST_NOTF, 0, 0, sccp_pkg::ACT_NONE, 0, 1);
            end
            sccp_pkg::OP_RELEASE:
            begin
                if (ex) wr[s] = 0;
                else if (rd[s] != 0) rd[s]--;
                push(sccp_pkg::ST_OK, s, 0, sccp_pkg::ACT_NONE, 0, 1);
            end
            sccp_pkg::OP_GET, sccp_pkg::OP_DIRTY, sccp_pkg::OP_FLUSH:
            begin
                if (!vld[s]) push(sccp_pkg::ST_NOTF, s, 0, sccp_pkg::ACT_NONE, 0, 1);
                else if (op == sccp_pkg::OP_GET)
                begin
                    if (zf)
                    begin
                        drt[s] = 1; fil[s] = 1;
                        push(sccp_pkg::ST_OK, s, 0, sccp_pkg::ACT_ZERO, 0, 1);
                    end
                    else if (!fil[s])
                    begin
                        drt[s] = 0; fil[s] = 1;
                        push(sccp_pkg::ST_OK, s, 0, sccp_pkg::ACT_READ, tags[s], 1);
                    end
                    else push(sccp_pkg::ST_OK, s, 0, sccp_pkg::ACT_NONE, 0, 1);
                    acc[s] = 1;
                end
                else if (op == sccp_pkg::OP_DIRTY)
                begin
                    if (!fil[s]) push(sccp_pkg::ST_NODATA, s, 0, sccp_pkg::ACT_NONE, 0, 1);
                    else
                    begin
                        drt[s] = 1;
                        push(sccp_pkg::ST_OK, s, 0, sccp_pkg::ACT_NONE, 0, 1);
                    end
                end
                else if (locked(s)) push(sccp_pkg::ST_BUSY, s, 0, sccp_pkg::ACT_NONE, 0, 1);
                else if (fil[s] && drt[s])
                begin
                    drt[s] = 0;
                    push(sccp_pkg::ST_OK, s, 0, sccp_pkg::ACT_WB, tags[s], 1);
                end
                else push(sccp_pkg::ST_OK, s, 0, sccp_pkg::ACT_NONE, 0, 1);
            end
            default: push(sccp_pkg::ST_OK, 0, 0, sccp_pkg::ACT_NONE, 0, 1);
        endcase
    endfunction

    function void check_result(cache_result_t got);
        cache_result_t want;
        if (pending.size() == 0)
        begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
            return;
        end
        want = pending.pop_front();
        if (got !== want)
        begin
            errors++;
            if (errors <= 10) $display("result mismatch: expected %p got %p", want, got);
        end
    endfunction
endclass

module tb_sector_cache_clock_policy;
    logic        clk, rst_n;
    logic        in_valid, in_ready, out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  operation;
    logic [31:0] sector;
    logic        exclusive, zero_fill;
    logic [5:0]  slot;
    logic [1:0]  status, action;
    logic [5:0]  slot_index;
    logic        hit, last;
    logic [31:0] disk_sector;

    int            send_idle, recv_idle;
    longint        cycles = 0;
    cache_scoreboard sb;
    logic [31:0]   sector_pool[8];

    sector_cache_clock_policy DUT (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // receiver: random stall, check on every accepted result
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({status, slot_index, hit, action, disk_sector, last});
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 2000000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_item(logic [2:0] op, logic [31:0] sec, bit ex, bit zf,
                             logic [5:0] sl);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1; operation <= op; sector <= sec;
        exclusive <= ex; zero_fill <= zf; slot <= sl;
        do @(posedge clk); while (!in_ready);
        sb.note_item(op, sec, ex, zf, sl);
    endtask

    task automatic send_random();
        int  k;
        logic [2:0] op;
        logic [31:0] sec;
        k = $urandom_range(99);
        sec = (k < 85) ? sector_pool[$urandom_range(7)] + $urandom_range(80)
                       : $urandom;
        if (k < 40) op = sccp_pkg::OP_ACQUIRE;
        else if (k < 55) op = sccp_pkg::OP_RELEASE;
        else if (k < 72) op = sccp_pkg::OP_GET;
        else if (k < 80) op = sccp_pkg::OP_DIRTY;
        else if (k < 88) op = sccp_pkg::OP_DEALLOC;
        else if (k < 97) op = sccp_pkg::OP_FLUSH;
        else op = 3'($urandom_range(7));
        send_item(op, sec, $urandom_range(1), $urandom_range(1), 6'($urandom));
    endtask

    initial
    begin
        sb = new();
        rst_n = 0; in_valid = 0; operation = '0; sector = '0;
        exclusive = 0; zero_fill = 0; slot = '0;
        send_idle = 30; recv_idle = 67;
        sector_pool = '{32'h0, 32'h1000, 32'h7FFF_FFF0, 32'hFFFF_FF80,
                        32'hA5A5_0000, 32'h5A5A_0000, 32'h0001_0000, 32'hC000_0000};
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: field extremes, every operation, special cases
        send_item(sccp_pkg::OP_ACQUIRE, 32'hFFFF_FFFF, 1, 0, 0);
        send_item(sccp_pkg::OP_ACQUIRE, 32'hFFFF_FFFF, 0, 0, 0);  // lock conflict on hit
        send_item(sccp_pkg::OP_GET, 0, 0, 0, 0);                  // read from disk
        send_item(sccp_pkg::OP_DIRTY, 0, 0, 0, 0);
        send_item(sccp_pkg::OP_FLUSH, 0, 0, 0, 0);                // locked: busy
        send_item(sccp_pkg::OP_DEALLOC, 32'hFFFF_FFFF, 0, 0, 0);  // locked: busy
        send_item(sccp_pkg::OP_RELEASE, 0, 0, 0, 0);              // no matching lock
        send_item(sccp_pkg::OP_RELEASE, 0, 1, 0, 0);
        send_item(sccp_pkg::OP_FLUSH, 0, 0, 0, 0);                // write-back
        send_item(sccp_pkg::OP_ACQUIRE, 0, 0, 0, 0);
        send_item(sccp_pkg::OP_DIRTY, 0, 0, 0, 1);                // not filled
        send_item(sccp_pkg::OP_GET, 0, 0, 1, 1);                  // zero fill
        send_item(sccp_pkg::OP_GET, 0, 0, 0, 63);                 // empty slot
        send_item(sccp_pkg::OP_FLUSH, 0, 1, 1, 62);
        send_item(sccp_pkg::OP_DEALLOC, 32'h1234_5678, 0, 0, 0);  // absent
        send_item(3'd6, 32'hFFFF_FFFF, 1, 1, 63);
        send_item(3'd7, 0, 0, 0, 0);
        send_item(sccp_pkg::OP_RELEASE, 0, 0, 0, 1);
        send_item(sccp_pkg::OP_DEALLOC, 0, 0, 0, 0);
        // fill every slot, then force evictions and a full-lock busy
        for (int i = 0; i < 70; i++)
        begin
            send_item(sccp_pkg::OP_ACQUIRE, 32'h0100_0000 + i, 1, 0, 0);
            if (i < 64)
                send_item(sccp_pkg::OP_GET, 0, 0, i[0], 6'(i));
        end
        for (int i = 0; i < 64; i++)
            send_item(sccp_pkg::OP_RELEASE, 0, 1, 0, 6'(i));

        for (int n = 0; n < 480; n++)
        begin
            if (n == 160)
            begin
                send_idle = 67; recv_idle = 30;
            end
            if (n == 320)
            begin
                send_idle = 0; recv_idle = 0;
            end
            send_random();
        end
        in_valid <= 0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ----- sim.f -----
design/sccp_pkg.sv
design/sector_cache_clock_policy.sv
verif/tb_sector_cache_clock_policy.sv
